/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside of reset.
`define CFTB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Consequence that must hold in the clock cycle after the antecedent.
`define CFTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/cftb_pkg.sv */
// Shared types and constants of the CAN frame trace buffer.
package cftb_pkg;

	// Default number of frames held in the history ring.
	localparam int HISTORY_DEPTH_DEF = 16;

	// Fixed field widths.
	localparam int TIME_W    = 32;
	localparam int BUS_W     = 2;
	localparam int ID_W      = 29;
	localparam int LEN_W     = 4;
	localparam int PAYLOAD_W = 64;
	localparam int QIDX_W    = 8;
	localparam int STAT_W    = 32;
	localparam int WCNT_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Compare width for an entry age against the fill count (depth up to 511).
	localparam int CMP_W = 9;

	// Rate divider: dividend is window count times 1000, divisor is elapsed ms.
	localparam int DVD_W = 26;
	localparam int DVS_W = 32;
	localparam logic [DVD_W-1:0] RATE_SCALE = DVD_W'(1000);
	localparam logic [WCNT_W-1:0] WCNT_MAX = 16'hFFFF;

	// Longest stored data length code.
	localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;

	// Request operation codes.
	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_READ  = 2'd1,
		OP_STAT  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CAPTURE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_LIMIT = 2'd3;

	// Statistic selects.
	localparam int NUM_CNT = 5;
	localparam logic [QIDX_W-1:0] STAT_TOTAL = 8'd0;
	localparam logic [QIDX_W-1:0] STAT_BUS0  = 8'd1;
	localparam logic [QIDX_W-1:0] STAT_BUS1  = 8'd2;
	localparam logic [QIDX_W-1:0] STAT_STD   = 8'd3;
	localparam logic [QIDX_W-1:0] STAT_EXT   = 8'd4;
	localparam logic [QIDX_W-1:0] STAT_RATE  = 8'd5;

	// One stored history entry.
	typedef struct packed {
		logic [TIME_W-1:0]    time_ms;
		logic [BUS_W-1:0]     bus;
		logic [ID_W-1:0]      id;
		logic                 extended;
		logic [LEN_W-1:0]     length;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic frame;
		logic window;
		logic div_apply;
		logic store;
		logic rd_issue;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		opcode_t op;
		logic    capture;
		logic    win_due;
		logic    div_done;
		logic    out_free;
	} status_t;

endpackage

/* sv/can_frame_trace_buffer.sv */
// Top level of the CAN frame trace buffer.
//
// Requests enter on the input channel (in_valid, in_stall) and each one gives
// exactly one result on the output channel (out_valid, out_stall). A request
// is taken at a clock edge with in_valid high and in_stall low. Opcode 0 logs
// a frame, 1 reads a history entry by age (0 is newest), 2 reads a statistic.
// Configuration registers are written over cfg_valid/cfg_ready (always high);
// the user must make writes while no request is in flight; this is not enforced.
// One request is worked on at a time. Opcodes 2 and 3 go from dispatch
// straight to the result stage, a history read passes the read state, and a
// frame passes the frame, window and store states; a frame that closes a rate
// window also waits for the 26-step bit-serial rate divider. The next request
// can be taken at the clock edge after the result is loaded.
// A finished result waits in the output register while the receiver stalls;
// the next request is taken meanwhile and held before its own result stage.
// Asynchronous reset clears counters, the ring fill and the rate window and
// loads the register defaults (capture on, hold off, 1000 ms, limit 1000).
module can_frame_trace_buffer #(
	parameter int HISTORY_DEPTH = cftb_pkg::HISTORY_DEPTH_DEF,
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic [cftb_pkg::TIME_W-1:0]     frame_time_ms,
	input  logic [cftb_pkg::BUS_W-1:0]      frame_bus,
	input  logic [cftb_pkg::ID_W-1:0]       frame_id,
	input  logic                            frame_extended,
	input  logic [cftb_pkg::LEN_W-1:0]      frame_length,
	input  logic [cftb_pkg::PAYLOAD_W-1:0]  frame_payload,
	input  logic [cftb_pkg::QIDX_W-1:0]     query_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            entry_valid,
	output logic [cftb_pkg::TIME_W-1:0]     entry_time_ms,
	output logic [cftb_pkg::BUS_W-1:0]      entry_bus,
	output logic [cftb_pkg::ID_W-1:0]       entry_id,
	output logic                            entry_extended,
	output logic [cftb_pkg::LEN_W-1:0]      entry_length,
	output logic [cftb_pkg::PAYLOAD_W-1:0]  entry_payload,
	output logic [FILL_W-1:0]               history_fill,
	output logic                            overloaded,
	output logic [cftb_pkg::STAT_W-1:0]     stat_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cftb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cftb_pkg::CFG_DAT_W-1:0]  cfg_data
);

	cftb_pkg::cmd_t    cmd;
	cftb_pkg::status_t status;
	cftb_pkg::entry_t  entry;

	assign cfg_ready = 1'b1;

	cftb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cftb_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.frame_time_ms  (frame_time_ms),
		.frame_bus      (frame_bus),
		.frame_id       (frame_id),
		.frame_extended (frame_extended),
		.frame_length   (frame_length),
		.frame_payload  (frame_payload),
		.query_index    (query_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.entry_valid    (entry_valid),
		.entry          (entry),
		.history_fill   (history_fill),
		.overloaded     (overloaded),
		.stat_value     (stat_value)
	);

	// Unpack the stored entry onto the result ports.
	assign entry_time_ms  = entry.time_ms;
	assign entry_bus      = entry.bus;
	assign entry_id       = entry.id;
	assign entry_extended = entry.extended;
	assign entry_length   = entry.length;
	assign entry_payload  = entry.payload;

endmodule

/* sv/cftb_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
module cftb_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cftb_pkg::DVD_W-1:0]  dividend,
	input  logic [cftb_pkg::DVS_W-1:0]  divisor,
	output logic [cftb_pkg::DVD_W-1:0]  quotient,
	output logic                        done
);

	localparam int CNT_W = $clog2(cftb_pkg::DVD_W);

	logic [cftb_pkg::DVD_W-1:0] quo_q;
	logic [cftb_pkg::DVS_W-1:0] rem_q;
	logic [cftb_pkg::DVS_W-1:0] den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [cftb_pkg::DVS_W:0]   shifted;
	logic [cftb_pkg::DVS_W:0]   diff;
	logic                       ge;

	// One trial subtraction of the shifted remainder.
	assign shifted = {rem_q, quo_q[cftb_pkg::DVD_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(cftb_pkg::DVD_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[cftb_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[cftb_pkg::DVS_W-1:0] : shifted[cftb_pkg::DVS_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* sv/cftb_datapath.sv */
// Datapath: item register, counters, rate window, history memory and result register.
module cftb_datapath #(
	parameter int HISTORY_DEPTH = cftb_pkg::HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(HISTORY_DEPTH),
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cftb_pkg::cmd_t                  cmd,
	output cftb_pkg::status_t               status,
	input  logic                            cfg_valid,
	input  logic [cftb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cftb_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic [1:0]                      opcode,
	input  logic [cftb_pkg::TIME_W-1:0]     frame_time_ms,
	input  logic [cftb_pkg::BUS_W-1:0]      frame_bus,
	input  logic [cftb_pkg::ID_W-1:0]       frame_id,
	input  logic                            frame_extended,
	input  logic [cftb_pkg::LEN_W-1:0]      frame_length,
	input  logic [cftb_pkg::PAYLOAD_W-1:0]  frame_payload,
	input  logic [cftb_pkg::QIDX_W-1:0]     query_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            entry_valid,
	output cftb_pkg::entry_t                entry,
	output logic [FILL_W-1:0]               history_fill,
	output logic                            overloaded,
	output logic [cftb_pkg::STAT_W-1:0]     stat_value
);

	// Configuration registers.
	logic                          capture_q;
	logic                          hold_q;
	logic [cftb_pkg::WCNT_W-1:0]   window_ms_q;
	logic [cftb_pkg::WCNT_W-1:0]   limit_q;

	// Current request.
	cftb_pkg::opcode_t             op_q;
	cftb_pkg::entry_t              item_q;
	logic [cftb_pkg::QIDX_W-1:0]   qidx_q;

	// Statistics and rate window state.
	logic [cftb_pkg::STAT_W-1:0]   cnt_q [cftb_pkg::NUM_CNT];
	logic [cftb_pkg::TIME_W-1:0]   start_q;
	logic [cftb_pkg::WCNT_W-1:0]   wcount_q;
	logic [cftb_pkg::WCNT_W-1:0]   rate_q;
	logic                          ovl_q;

	// History ring.
	cftb_pkg::entry_t              mem_q [HISTORY_DEPTH];
	logic [AW-1:0]                 slot_q;
	logic [FILL_W-1:0]             fill_q;
	cftb_pkg::entry_t              rd_entry_q;
	logic                          rd_hit_q;

	// Result register.
	logic                          out_valid_q;
	logic                          entry_valid_q;
	cftb_pkg::entry_t              entry_q;
	logic [FILL_W-1:0]             fill_out_q;
	logic                          ovl_out_q;
	logic [cftb_pkg::STAT_W-1:0]   stat_q;

	logic [cftb_pkg::TIME_W-1:0]   elapsed;
	logic                          win_due;
	logic [cftb_pkg::DVD_W-1:0]    dividend;
	logic [cftb_pkg::DVS_W-1:0]    divisor;
	logic [cftb_pkg::DVD_W-1:0]    quotient;
	logic                          div_done;
	logic                          div_start;
	logic                          out_free;
	logic [AW:0]                   age_sum;
	logic [AW-1:0]                 rd_addr;
	logic                          rd_hit;
	logic [cftb_pkg::STAT_W-1:0]   stat_sel;
	logic                          store_en;

	// Window length and rate division operands.
	assign elapsed   = item_q.time_ms - start_q;
	assign win_due   = elapsed >= {16'd0, window_ms_q};
	assign dividend  = cftb_pkg::DVD_W'(wcount_q) * cftb_pkg::RATE_SCALE;
	assign divisor   = (elapsed == '0) ? cftb_pkg::DVS_W'(1) : elapsed;
	assign div_start = cmd.window && capture_q && win_due;

	cftb_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign store_en = !(hold_q || ovl_q);

	assign status = '{op: op_q, capture: capture_q, win_due: win_due,
		div_done: div_done, out_free: out_free};

	// Slot of the entry of the given age, newest first.
	assign age_sum = (AW+1)'(slot_q) + (AW+1)'(HISTORY_DEPTH - 1) - (AW+1)'(qidx_q);
	assign rd_addr = (age_sum >= (AW+1)'(HISTORY_DEPTH)) ?
		AW'(age_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(age_sum);
	assign rd_hit  = {1'b0, qidx_q} < cftb_pkg::CMP_W'(fill_q);

	// Statistic select.
	always_comb begin
		case (qidx_q)
			cftb_pkg::STAT_TOTAL: stat_sel = cnt_q[0];
			cftb_pkg::STAT_BUS0:  stat_sel = cnt_q[1];
			cftb_pkg::STAT_BUS1:  stat_sel = cnt_q[2];
			cftb_pkg::STAT_STD:   stat_sel = cnt_q[3];
			cftb_pkg::STAT_EXT:   stat_sel = cnt_q[4];
			cftb_pkg::STAT_RATE:  stat_sel = {16'd0, rate_q};
			default:              stat_sel = '0;
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q   <= 1'b1;
			hold_q      <= 1'b0;
			window_ms_q <= 16'd1000;
			limit_q     <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				cftb_pkg::CFG_CAPTURE_MODE:   capture_q   <= cfg_data[0];
				cftb_pkg::CFG_HOLD_CAPTURE:   hold_q      <= cfg_data[0];
				cftb_pkg::CFG_WINDOW_MS:      window_ms_q <= cfg_data;
				cftb_pkg::CFG_OVERLOAD_LIMIT: limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request capture; the stored length is clamped here.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q                 <= cftb_pkg::opcode_t'(opcode);
			item_q.time_ms       <= frame_time_ms;
			item_q.bus           <= frame_bus;
			item_q.id            <= frame_id;
			item_q.extended      <= frame_extended;
			item_q.length        <= (frame_length > cftb_pkg::LEN_MAX) ?
				cftb_pkg::LEN_MAX : frame_length;
			item_q.payload       <= frame_payload;
			qidx_q               <= query_index;
		end
	end

	// Event counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cftb_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.frame) begin
			cnt_q[0] <= cnt_q[0] + 1'b1;
			if (item_q.bus == 2'd0) begin
				cnt_q[1] <= cnt_q[1] + 1'b1;
			end
			if (item_q.bus == 2'd1) begin
				cnt_q[2] <= cnt_q[2] + 1'b1;
			end
			if (item_q.extended) begin
				cnt_q[4] <= cnt_q[4] + 1'b1;
			end else begin
				cnt_q[3] <= cnt_q[3] + 1'b1;
			end
		end
	end

	// Rate window: open, count, and close with the divider result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			wcount_q <= '0;
			rate_q   <= '0;
			ovl_q    <= 1'b0;
		end else if (cmd.frame) begin
			if (!capture_q) begin
				start_q  <= '0;
				wcount_q <= '0;
				rate_q   <= '0;
				ovl_q    <= 1'b0;
			end else if (start_q == '0) begin
				start_q  <= item_q.time_ms;
				wcount_q <= '0;
				rate_q   <= '0;
				ovl_q    <= 1'b0;
			end
		end else if (cmd.window && capture_q && !win_due) begin
			if (wcount_q != cftb_pkg::WCNT_MAX) begin
				wcount_q <= wcount_q + 1'b1;
			end
		end else if (cmd.div_apply) begin
			rate_q   <= (quotient > cftb_pkg::DVD_W'(cftb_pkg::WCNT_MAX)) ?
				cftb_pkg::WCNT_MAX : quotient[cftb_pkg::WCNT_W-1:0];
			ovl_q    <= quotient > cftb_pkg::DVD_W'(limit_q);
			start_q  <= item_q.time_ms;
			wcount_q <= cftb_pkg::WCNT_W'(1);
		end
	end

	// Ring write pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (cmd.store && store_en) begin
			slot_q <= (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// History memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.store && store_en) begin
			mem_q[slot_q] <= item_q;
		end
		if (cmd.rd_issue) begin
			rd_entry_q <= mem_q[rd_addr];
			rd_hit_q   <= rd_hit;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			entry_valid_q <= (op_q == cftb_pkg::OP_READ) && rd_hit_q;
			entry_q       <= ((op_q == cftb_pkg::OP_READ) && rd_hit_q) ? rd_entry_q : '0;
			stat_q        <= (op_q == cftb_pkg::OP_STAT) ? stat_sel : '0;
			fill_out_q    <= fill_q;
			ovl_out_q     <= ovl_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign entry_valid  = entry_valid_q;
	assign entry        = entry_q;
	assign history_fill = fill_out_q;
	assign overloaded   = ovl_out_q;
	assign stat_value   = stat_q;

endmodule

/* sv/cftb_ctrl.sv */
// Controller state machine that sequences each request through the datapath.
module cftb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cftb_pkg::status_t status,
	output cftb_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FRAME,
		ST_WINDOW,
		ST_DIVIDE,
		ST_DIVEND,
		ST_STORE,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t state_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					case (status.op)
						cftb_pkg::OP_FRAME: state_q <= ST_FRAME;
						cftb_pkg::OP_READ:  state_q <= ST_READ;
						default:            state_q <= ST_EMIT;
					endcase
				end
				ST_FRAME:  state_q <= ST_WINDOW;
				ST_WINDOW: begin
					if (status.capture && status.win_due) begin
						state_q <= ST_DIVIDE;
					end else begin
						state_q <= ST_STORE;
					end
				end
				ST_DIVIDE: begin
					if (status.div_done) begin
						state_q <= ST_DIVEND;
					end
				end
				ST_DIVEND: state_q <= ST_STORE;
				ST_STORE:  state_q <= ST_EMIT;
				ST_READ:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Commands decoded from the state.
	always_comb begin
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.frame     = state_q == ST_FRAME;
		cmd.window    = state_q == ST_WINDOW;
		cmd.div_apply = state_q == ST_DIVEND;
		cmd.store     = state_q == ST_STORE;
		cmd.rd_issue  = state_q == ST_READ;
		cmd.emit      = (state_q == ST_EMIT) && status.out_free;
	end

	assign in_stall = state_q != ST_IDLE;

endmodule

/* sv/cftb_checker.sv */
// Port-level checker of the CAN frame trace buffer and its bind statement.
`include "assert_macros.svh"

module cftb_checker #(
	parameter int HISTORY_DEPTH = cftb_pkg::HISTORY_DEPTH_DEF,
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1)
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            entry_valid,
	input logic [cftb_pkg::TIME_W-1:0]     entry_time_ms,
	input logic [cftb_pkg::BUS_W-1:0]      entry_bus,
	input logic [cftb_pkg::ID_W-1:0]       entry_id,
	input logic                            entry_extended,
	input logic [cftb_pkg::LEN_W-1:0]      entry_length,
	input logic [cftb_pkg::PAYLOAD_W-1:0]  entry_payload,
	input logic [FILL_W-1:0]               history_fill,
	input logic [cftb_pkg::STAT_W-1:0]     stat_value
);

	// A stalled result stays offered.
	`CFTB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// One request at a time: after a request is taken the input stalls.
	`CFTB_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)

	// The ring never reports more frames than it holds.
	`CFTB_ASSERT(a_fill_bound, clk, arst_n,
		!out_valid || (history_fill <= FILL_W'(HISTORY_DEPTH)))

	// A missed or non-read result carries a cleared entry.
	`CFTB_ASSERT(a_entry_clear, clk, arst_n,
		!(out_valid && !entry_valid) || (entry_time_ms == '0 && entry_bus == '0 && entry_id == '0 && entry_extended == 1'b0 && entry_length == '0 && entry_payload == '0))

	// A hit entry has a clamped length and no statistic beside it.
	`CFTB_ASSERT(a_entry_hit, clk, arst_n,
		!(out_valid && entry_valid) || (entry_length <= cftb_pkg::LEN_MAX && stat_value == '0))

endmodule

bind can_frame_trace_buffer cftb_checker #(
	.HISTORY_DEPTH (HISTORY_DEPTH)
) u_cftb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.entry_valid    (entry_valid),
	.entry_time_ms  (entry_time_ms),
	.entry_bus      (entry_bus),
	.entry_id       (entry_id),
	.entry_extended (entry_extended),
	.entry_length   (entry_length),
	.entry_payload  (entry_payload),
	.history_fill   (history_fill),
	.stat_value     (stat_value)
);
